@@ rtl/tae_pkg.sv @@
// Shared types and constants for the Thumb ALU execute block.
// Standalone; thumb_alu_execute and tae_alu import it.
`timescale 1ns / 1ps
`default_nettype none

package tae_pkg;

  localparam int WORD_W   = 32;
  localparam int ACT_W    = 5;
  localparam int IDX_W    = 4;
  localparam int IMM_W    = 8;
  localparam int RF_DEPTH = 16;

  localparam logic [IDX_W-1:0] PC_INDEX = 4'd15;

  typedef enum logic [ACT_W-1:0] {
    ACT_MOV_IMM    = 5'd0,
    ACT_ADD_REG    = 5'd1,
    ACT_ADD_IMM    = 5'd2,
    ACT_ADD_IMM_RD = 5'd3,
    ACT_SUB_REG    = 5'd4,
    ACT_SUB_IMM    = 5'd5,
    ACT_SUB_IMM_RD = 5'd6,
    ACT_CMP_IMM    = 5'd7,
    ACT_LSL_IMM    = 5'd8,
    ACT_LSR_IMM    = 5'd9,
    ACT_ASR_IMM    = 5'd10,
    ACT_AND        = 5'd11,
    ACT_EOR        = 5'd12,
    ACT_LSL_REG    = 5'd13,
    ACT_LSR_REG    = 5'd14,
    ACT_ASR_REG    = 5'd15,
    ACT_ADC        = 5'd16,
    ACT_SBC        = 5'd17,
    ACT_ROR        = 5'd18,
    ACT_TST        = 5'd19,
    ACT_NEG        = 5'd20,
    ACT_CMP        = 5'd21,
    ACT_CMN        = 5'd22,
    ACT_ORR        = 5'd23,
    ACT_MUL        = 5'd24,
    ACT_BIC        = 5'd25,
    ACT_MVN        = 5'd26,
    ACT_ADD_HI     = 5'd27,
    ACT_CMP_HI     = 5'd28,
    ACT_MOV_HI     = 5'd29
  } action_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  dest_index;
    logic [IDX_W-1:0]  src_index;
    logic [IDX_W-1:0]  second_index;
    logic [IMM_W-1:0]  immediate;
  } in_beat_t;

  typedef struct packed {
    logic              write_enable;
    logic [IDX_W-1:0]  write_index;
    logic [WORD_W-1:0] write_value;
    logic              flag_n;
    logic              flag_z;
    logic              flag_c;
    logic              flag_v;
  } out_beat_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic              wr;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] value;
    flags_t            flags;
  } alu_res_t;

endpackage

`default_nettype wire

@@ rtl/thumb_alu_execute.sv @@
// Thumb ALU execute: one data-processing instruction per beat.
// Flow: read at command accept, then execute in stage 1. Throughput: one beat per cycle
//   unless stalled; the register file read port and the write of the previous beat are
//   joined by a one-entry bypass, and flags update at the execute edge.
// Reset: clears pipeline valids, flags and the per-register written bits, so every
//   register reads as zero until written. No clearing pass; ready straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module thumb_alu_execute (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  tae_pkg::in_beat_t  cmd,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tae_pkg::out_beat_t rsp
);
  import tae_pkg::*;

  logic                cmd_take;
  logic                s1_valid;
  in_beat_t            s1_beat;
  logic                s1_advance;
  in_beat_t            rd_beat;
  logic [IDX_W-1:0]    rd_index_a;
  logic [IDX_W-1:0]    s1_index_a;
  logic [WORD_W-1:0]   rdata_a;
  logic [WORD_W-1:0]   rdata_b;
  logic                rd_ok_a;
  logic                rd_ok_b;
  logic [RF_DEPTH-1:0] written;
  logic                last_wr;
  logic [IDX_W-1:0]    last_index;
  logic [WORD_W-1:0]   last_value;
  logic [WORD_W-1:0]   p1_value;
  logic [WORD_W-1:0]   src_value;
  flags_t              flags;
  alu_res_t            alu_res;

  // Three-register add and subtract read rn on port A in place of rd.
  function automatic logic [IDX_W-1:0] port_a_index(in_beat_t b);
    logic three_reg;
    three_reg = (b.action == ACT_ADD_REG) || (b.action == ACT_SUB_REG);
    return three_reg ? b.second_index : b.dest_index;
  endfunction

  assign s1_advance = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall  = s1_valid && !s1_advance;
  assign cmd_take   = cmd_valid && !cmd_stall;

  // Hold the read address while the beat waits in stage 1.
  assign rd_beat    = cmd_take ? cmd : s1_beat;
  assign rd_index_a = port_a_index(rd_beat);
  assign s1_index_a = port_a_index(s1_beat);

  tae_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RF_DEPTH)
  ) u_rf (
    .clk     (clk),
    .we      (s1_advance && alu_res.wr),
    .waddr   (alu_res.index),
    .wdata   (alu_res.value),
    .raddr_a (rd_index_a),
    .rdata_a (rdata_a),
    .raddr_b (rd_beat.src_index),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    rd_ok_a <= written[rd_index_a];
    rd_ok_b <= written[rd_beat.src_index];
  end

  // The read is registered, so only the most recent write can be missing.
  assign p1_value  = (last_wr && last_index == s1_index_a) ? last_value :
                     (rd_ok_a ? rdata_a : '0);
  assign src_value = (last_wr && last_index == s1_beat.src_index) ? last_value :
                     (rd_ok_b ? rdata_b : '0);

  tae_alu u_alu (
    .beat      (s1_beat),
    .p1_value  (p1_value),
    .src_value (src_value),
    .flags     (flags),
    .res       (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      last_wr   <= 1'b0;
      written   <= '0;
      flags     <= '0;
    end else begin
      if (cmd_take) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        rsp_valid <= 1'b1;
        flags     <= alu_res.flags;
        last_wr   <= alu_res.wr;
        if (alu_res.wr) begin
          written[alu_res.index] <= 1'b1;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_beat <= cmd;
    end
    if (s1_advance) begin
      last_index       <= alu_res.index;
      last_value       <= alu_res.value;
      rsp.write_enable <= alu_res.wr;
      rsp.write_index  <= alu_res.index;
      rsp.write_value  <= alu_res.value;
      rsp.flag_n       <= alu_res.flags.n;
      rsp.flag_z       <= alu_res.flags.z;
      rsp.flag_c       <= alu_res.flags.c;
      rsp.flag_v       <= alu_res.flags.v;
    end
  end

`ifndef SYNTHESIS
  a_take_fills_s1: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> s1_valid)
    else $error("accepted command beat did not reach stage 1");

  a_rsp_flags_match: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> rsp_valid && rsp.flag_n == flags.n && rsp.flag_z == flags.z &&
                   rsp.flag_c == flags.c && rsp.flag_v == flags.v)
    else $error("result flags differ from the flag register");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    s1_advance && alu_res.wr |=> last_wr && written[last_index])
    else $error("register write not recorded in written bits or bypass");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.write_enable |-> rsp.write_index == '0 && rsp.write_value == '0)
    else $error("result without a write carries a non-zero index or value");
`endif

endmodule

`default_nettype wire

@@ rtl/tae_ram.sv @@
// Generic RAM: one write port, two registered read ports.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ rtl/tae_alu.sv @@
// Combinational execute path: shared adder, barrel shifter, logic ops, multiply, flags.
// Depends on tae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tae_alu (
  input  tae_pkg::in_beat_t           beat,
  input  logic [tae_pkg::WORD_W-1:0]  p1_value,   // rd, or rn for three-register add/sub
  input  logic [tae_pkg::WORD_W-1:0]  src_value,
  input  tae_pkg::flags_t             flags,
  output tae_pkg::alu_res_t           res
);
  import tae_pkg::*;

  localparam int SH_W = 6;
  localparam logic [SH_W-1:0] SH_FULL = SH_W'(WORD_W);
  localparam logic [SH_W-1:0] SH_OUT  = SH_W'(WORD_W + 1);
  localparam logic [WORD_W-1:0] PC_STEP = WORD_W'(2);

  typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} shift_kind_t;

  logic [WORD_W-1:0]   imm_word;
  logic [WORD_W-1:0]   add_a;
  logic [WORD_W-1:0]   add_b;
  logic                add_cin;
  logic [WORD_W:0]     sum;
  logic                add_v;
  logic [IMM_W-1:0]    amt;
  logic [4:0]          sh5;
  logic [WORD_W-1:0]   sh_in;
  logic [SH_W-1:0]     sh_k;
  shift_kind_t         sh_kind;
  logic                sh_cupd;
  logic [WORD_W:0]     lsl_ext;
  logic [WORD_W:0]     lsr_ext;
  logic [WORD_W:0]     asr_ext;
  logic [2*WORD_W-1:0] ror_ext;
  logic [WORD_W-1:0]   sh_out;
  logic                sh_c;
  logic [WORD_W-1:0]   mul_out;
  logic [WORD_W-1:0]   r;
  logic [WORD_W-1:0]   wval;
  logic                wr;
  logic                pc_fix;
  logic                set_nz;
  logic                set_cv;

  assign imm_word = {{(WORD_W-IMM_W){1'b0}}, beat.immediate};
  assign amt      = src_value[IMM_W-1:0];
  assign sh5      = beat.immediate[4:0];
  assign mul_out  = p1_value * src_value;

  // Operand selection for the shared adder; subtraction is a + ~b + 1 (a + ~b + C for SBC).
  always_comb begin
    add_a   = p1_value;
    add_b   = src_value;
    add_cin = 1'b0;
    unique case (beat.action) inside
      ACT_ADD_REG: begin
        add_a = src_value;
        add_b = p1_value;
      end
      ACT_ADD_IMM: begin
        add_a = src_value;
        add_b = imm_word;
      end
      ACT_ADD_IMM_RD: begin
        add_b = imm_word;
      end
      ACT_SUB_REG: begin
        add_a   = src_value;
        add_b   = ~p1_value;
        add_cin = 1'b1;
      end
      ACT_SUB_IMM: begin
        add_a   = src_value;
        add_b   = ~imm_word;
        add_cin = 1'b1;
      end
      ACT_SUB_IMM_RD, ACT_CMP_IMM: begin
        add_b   = ~imm_word;
        add_cin = 1'b1;
      end
      ACT_ADC: begin
        add_cin = flags.c;
      end
      ACT_SBC: begin
        add_b   = ~src_value;
        add_cin = flags.c;
      end
      ACT_NEG: begin
        add_a   = '0;
        add_b   = ~src_value;
        add_cin = 1'b1;
      end
      ACT_CMP, ACT_CMP_HI: begin
        add_b   = ~src_value;
        add_cin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_cin};
  assign add_v = ~(add_a[WORD_W-1] ^ add_b[WORD_W-1]) & (add_a[WORD_W-1] ^ sum[WORD_W-1]);

  // Shift set-up. Amounts past the word are clamped, rotates aside, so that the shifted-out
  // carry and the fill come out of the same extended shift.
  always_comb begin
    sh_in   = p1_value;
    sh_k    = '0;
    sh_kind = SH_LSL;
    sh_cupd = 1'b0;
    unique case (beat.action) inside
      ACT_LSL_IMM: begin
        sh_in   = src_value;
        sh_k    = {1'b0, sh5};
        sh_cupd = (sh5 != '0);
      end
      ACT_LSR_IMM, ACT_ASR_IMM: begin
        sh_in   = src_value;
        sh_k    = (sh5 == '0) ? SH_FULL : {1'b0, sh5};
        sh_kind = (beat.action == ACT_LSR_IMM) ? SH_LSR : SH_ASR;
        sh_cupd = 1'b1;
      end
      ACT_LSL_REG, ACT_LSR_REG: begin
        sh_k    = (amt >= {2'b00, SH_OUT}) ? SH_OUT : amt[SH_W-1:0];
        sh_kind = (beat.action == ACT_LSL_REG) ? SH_LSL : SH_LSR;
        sh_cupd = (amt != '0);
      end
      ACT_ASR_REG: begin
        sh_k    = (amt >= {2'b00, SH_FULL}) ? SH_FULL : amt[SH_W-1:0];
        sh_kind = SH_ASR;
        sh_cupd = (amt != '0);
      end
      ACT_ROR: begin
        sh_k    = {1'b0, amt[4:0]};
        sh_kind = SH_ROR;
        sh_cupd = (amt != '0);
      end
      default: begin
      end
    endcase
  end

  assign lsl_ext = {1'b0, sh_in} << sh_k;
  assign lsr_ext = {sh_in, 1'b0} >> sh_k;
  assign asr_ext = $signed({sh_in, 1'b0}) >>> sh_k;
  assign ror_ext = {sh_in, sh_in} >> sh_k[4:0];

  always_comb begin
    unique case (sh_kind)
      SH_LSL: begin
        sh_out = lsl_ext[WORD_W-1:0];
        sh_c   = lsl_ext[WORD_W];
      end
      SH_LSR: begin
        sh_out = lsr_ext[WORD_W:1];
        sh_c   = lsr_ext[0];
      end
      SH_ASR: begin
        sh_out = asr_ext[WORD_W:1];
        sh_c   = asr_ext[0];
      end
      default: begin
        // rotate: carry is the new top bit, also for a whole-word rotate
        sh_out = ror_ext[WORD_W-1:0];
        sh_c   = ror_ext[WORD_W-1];
      end
    endcase
  end

  always_comb begin
    r      = '0;
    wr     = 1'b0;
    pc_fix = 1'b0;
    set_nz = 1'b0;
    set_cv = 1'b0;
    unique case (beat.action) inside
      ACT_MOV_IMM: begin
        r      = imm_word;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      ACT_ADD_REG, ACT_ADD_IMM, ACT_ADD_IMM_RD, ACT_SUB_REG, ACT_SUB_IMM,
      ACT_SUB_IMM_RD, ACT_ADC, ACT_SBC, ACT_NEG: begin
        r      = sum[WORD_W-1:0];
        wr     = 1'b1;
        set_nz = 1'b1;
        set_cv = 1'b1;
      end
      ACT_CMP_IMM, ACT_CMP, ACT_CMN, ACT_CMP_HI: begin
        r      = sum[WORD_W-1:0];
        set_nz = 1'b1;
        set_cv = 1'b1;
      end
      ACT_LSL_IMM, ACT_LSR_IMM, ACT_ASR_IMM, ACT_LSL_REG, ACT_LSR_REG,
      ACT_ASR_REG, ACT_ROR: begin
        r      = sh_out;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      ACT_AND: begin
        r      = p1_value & src_value;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      ACT_EOR: begin
        r      = p1_value ^ src_value;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      ACT_ORR: begin
        r      = p1_value | src_value;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      ACT_BIC: begin
        r      = p1_value & ~src_value;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      ACT_TST: begin
        r      = p1_value & src_value;
        set_nz = 1'b1;
      end
      ACT_MUL: begin
        r      = mul_out;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      ACT_MVN: begin
        r      = ~src_value;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      ACT_ADD_HI: begin
        r      = sum[WORD_W-1:0];
        wr     = 1'b1;
        pc_fix = 1'b1;
      end
      ACT_MOV_HI: begin
        r      = src_value;
        wr     = 1'b1;
        pc_fix = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // High-register writes to the PC: drop the Thumb bit and step past the fetch.
  assign wval = (pc_fix && beat.dest_index == PC_INDEX) ?
                {r[WORD_W-1:1], 1'b0} + PC_STEP : r;

  assign res.wr      = wr;
  assign res.index   = wr ? beat.dest_index : '0;
  assign res.value   = wr ? wval : '0;
  assign res.flags.n = set_nz ? r[WORD_W-1] : flags.n;
  assign res.flags.z = set_nz ? (r == '0) : flags.z;
  assign res.flags.c = set_cv ? sum[WORD_W] : (sh_cupd ? sh_c : flags.c);
  assign res.flags.v = set_cv ? add_v : flags.v;

endmodule

`default_nettype wire
